FILE: rtl/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the stable merge sorter.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int DATA_W = 32;

  typedef logic [DATA_W-1:0] data_t;

endpackage

FILE: rtl/stable_merge_sorter.sv
// ----------------------------------------------------------------------------
// stable_merge_sorter
// Collects a run of signed values, sorts it stably with bottom-up merge
// passes and streams the run back in ascending order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, value, last): one value per item; last
// ends the run. Items past MAX_ITEMS are dropped and the whole run is then
// flagged with overflow. Loading accepts one item per cycle.
// After the last item, in_ready stays low while the block sorts. With n
// stored values there are ceil(log2 n) merge passes; each pass merges its
// pairs of runs one after another, all through the one comparator and the
// two-read-port ping-pong buffers.
// Output channel (out_valid/out_ready, value_res, last_res, overflow): one
// result at a time, a new one shown only once the current one is taken;
// last_res marks the final value. A stalled result holds in the output
// register until taken.
// Reset empties the run and returns to loading; buffer contents need no
// clearing since only written entries are read.
// ----------------------------------------------------------------------------
module stable_merge_sorter import sms_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_res,
  output logic        last_res,
  output logic        overflow
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_SEG, S_PRIME, S_MERGE, S_OUT_RD, S_OUT_SHOW, S_OUT_WAIT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] n;
  logic [SW-1:0] width;
  logic [SW-1:0] lo;
  logic [CW-1:0] mid, hi, i, j, k;
  logic          src_sel;

  data_t         b0_rda, b0_rdb, b1_rda, b1_rdb;
  data_t         rd_a, rd_b, mdata;
  logic          load_we, in_acc, i_lt, j_lt, take_i, seg_done, mwe;
  logic [CW-1:0] i_next, j_next, k_inc, mid_c, hi_c;
  logic [SW-1:0] sum_mid, lo2, n_ext;
  logic [AW-1:0] ra, rb, waddr0;
  logic          we0, we1;
  data_t         wdata0;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_we  = in_acc && (count < CW'(MAX_ITEMS));

  assign rd_a = src_sel ? b1_rda : b0_rda;
  assign rd_b = src_sel ? b1_rdb : b0_rdb;

  always_comb begin
    i_lt     = (i < mid);
    j_lt     = (j < hi);
    seg_done = !i_lt && !j_lt;
    take_i   = i_lt && (!j_lt || ($signed(rd_a) <= $signed(rd_b)));
    mwe      = (state == S_MERGE) && !seg_done;
    mdata    = take_i ? rd_a : rd_b;
    i_next   = (mwe && take_i) ? i + CW'(1) : i;
    j_next   = (mwe && !take_i) ? j + CW'(1) : j;
    k_inc    = k + CW'(1);
    n_ext    = SW'(n);
    sum_mid  = lo + width;
    lo2      = lo + (width << 1);
    mid_c    = (sum_mid < n_ext) ? sum_mid[CW-1:0] : n;
    hi_c     = (lo2 < n_ext) ? lo2[CW-1:0] : n;
  end

  // Read address: look ahead to the next pointers while merging.
  always_comb begin
    rb = j[AW-1:0];
    case (state)
      S_MERGE: begin
        ra = i_next[AW-1:0];
        rb = j_next[AW-1:0];
      end
      S_OUT_RD:   ra = k[AW-1:0];
      S_OUT_WAIT: ra = k_inc[AW-1:0];
      default:    ra = i[AW-1:0];
    endcase
  end

  always_comb begin
    we0    = load_we || (mwe && src_sel);
    we1    = mwe && !src_sel;
    waddr0 = (state == S_IDLE) ? count[AW-1:0] : k[AW-1:0];
    wdata0 = (state == S_IDLE) ? value : mdata;
  end

  sms_bank #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (b0_rda),
    .rdata_b (b0_rdb)
  );

  sms_bank #(.DEPTH(MAX_ITEMS), .AW(AW)) u_scratch (
    .clk     (clk),
    .we      (we1),
    .waddr   (k[AW-1:0]),
    .wdata   (mdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (b1_rda),
    .rdata_b (b1_rdb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      src_sel   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (load_we) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              n       <= load_we ? count + CW'(1) : count;
              width   <= SW'(1);
              src_sel <= 1'b0;
              state   <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (width < n_ext) begin
            lo    <= '0;
            state <= S_SEG;
          end else begin
            k     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_SEG: begin
          mid   <= mid_c;
          hi    <= hi_c;
          i     <= lo[CW-1:0];
          j     <= mid_c;
          k     <= lo[CW-1:0];
          state <= S_PRIME;
        end
        S_PRIME: state <= S_MERGE;
        S_MERGE: begin
          if (seg_done) begin
            lo <= lo2;
            if (lo2 >= n_ext) begin
              width   <= width << 1;
              src_sel <= !src_sel;
              state   <= S_PASS;
            end else begin
              state <= S_SEG;
            end
          end else begin
            i <= i_next;
            j <= j_next;
            k <= k_inc;
          end
        end
        S_OUT_RD: state <= S_OUT_SHOW;
        S_OUT_SHOW: begin
          value_res <= rd_a;
          last_res  <= (k_inc == n);
          overflow  <= dropped;
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_res) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_OUT_SHOW;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sms_bank.sv
// ----------------------------------------------------------------------------
// sms_bank
// Item buffer with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sms_bank import sms_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  data_t         wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output data_t         rdata_a,
  output data_t         rdata_b
);

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/sms_checker.sv
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks for the stable merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module sms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value_res,
  input logic        last_res,
  input logic        overflow
);

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // Stop loading once the run ends.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> !in_ready)
    else $error("still loading after final item");

  // Return to loading right after the final result is taken.
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_res) |=> (in_ready && !out_valid))
    else $error("not back to loading after final result");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(value_res) && $stable(last_res) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind stable_merge_sorter sms_checker u_sms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value_res (value_res),
  .last_res  (last_res),
  .overflow  (overflow)
);

FILE: bench/stable_merge_sorter_tb.sv
// ----------------------------------------------------------------------------
// stable_merge_sorter_tb
// Streams runs of signed values into the sorter with bursty input and a
// stalling receiver. A stable insertion-sort predictor builds the expected
// output stream, and each result is compared field by field. The runs
// include single values, extremes, duplicates, a full store and a run that
// overflows capacity, followed by random runs.
// ----------------------------------------------------------------------------
module stable_merge_sorter_tb;
  import sms_pkg::*;

  localparam int MAX_ITEMS   = 64;
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    data_t val;
    logic  is_last;
    logic  ovf;
  } sorted_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_THIRD, RX_COIN, RX_HOLD} rx_mode_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [31:0] value     = '0;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value_res;
  logic        last_res;
  logic        overflow;

  sorted_item_t sorted_q[$];
  data_t        run_vals[$];
  logic         run_dropped = 1'b0;
  int           mismatch_count = 0;
  int           burst_left = 0;
  int           cycle_count = 0;
  rx_mode_e     rx_mode = RX_OPEN;
  int           rx_left = 0;
  int           rx_tick = 0;

  stable_merge_sorter #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Collect the run; on last, sort it stably and queue the whole output run.
  function automatic void predict_sorted(input data_t val, input logic lst);
    data_t ordered[$];
    int    j;
    if (run_vals.size() < MAX_ITEMS) run_vals.push_back(val);
    else run_dropped = 1'b1;
    if (lst) begin
      foreach (run_vals[i]) begin
        j = ordered.size();
        // equal values stay behind earlier ones
        while (j > 0 && $signed(ordered[j-1]) > $signed(run_vals[i])) j--;
        ordered.insert(j, run_vals[i]);
      end
      foreach (ordered[i])
        sorted_q.push_back('{ordered[i], i == ordered.size() - 1, run_dropped});
      run_vals.delete();
      run_dropped = 1'b0;
    end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t: mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_results
    sorted_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result value=%0d last=%b ovf=%b",
                                $signed(value_res), last_res, overflow));
      end else begin
        want = sorted_q.pop_front();
        if (value_res !== want.val || last_res !== want.is_last || overflow !== want.ovf)
          note_mismatch($sformatf("expected value=%0d last=%b ovf=%b, got value=%0d last=%b ovf=%b",
                                  $signed(want.val), want.is_last, want.ovf,
                                  $signed(value_res), last_res, overflow));
      end
    end
  end

  // Receiver: switch between open, sparse, coin-flip and held-off stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(2, 25) : $urandom_range(8, 60);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_THIRD: out_ready <= (rx_tick % 3 == 0);
        RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
        default:  out_ready <= 1'b0;
      endcase
    end
  end

  task automatic send_item(input data_t val, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    value    <= val;
    last     <= lst;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_sorted(val, lst);
  endtask

  task automatic send_run(input data_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // Hold input off until every queued result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  function automatic data_t random_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return $urandom;
    if (r < 12) return data_t'($urandom_range(0, 8)) - 32'd4;
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return data_t'($urandom_range(0, 2000)) - 32'd1000;
  endfunction

  task automatic test_single_runs();
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b1);
  endtask

  task automatic test_extremes();
    data_t vals[$];
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
             32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001};
    send_run(vals);
  endtask

  task automatic test_equal_values();
    data_t vals[$];
    vals = '{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3};
    send_run(vals);
  endtask

  task automatic test_descending();
    data_t vals[$];
    for (int k = 0; k < 8; k++) vals.push_back(32'd100 - 32'(k * 30));
    send_run(vals);
  endtask

  task automatic test_full_capacity();
    for (int k = 0; k < MAX_ITEMS; k++)
      send_item(data_t'($urandom_range(0, 15)) - 32'd8, k == MAX_ITEMS - 1);
  endtask

  // One run that drops an inner item and its own final item, then a short
  // run that must come out clean.
  task automatic test_overflow();
    for (int k = 0; k < MAX_ITEMS + 2; k++) send_item(random_value(), k == MAX_ITEMS + 1);
    wait_drained();
    send_item(32'h0000_002A, 1'b1);
  endtask

  task automatic test_random_runs();
    int sent;
    int run_len;
    int r;
    sent = 0;
    while (sent < 12) begin
      r = $urandom_range(0, 19);
      if (r < 16) run_len = $urandom_range(1, 6);
      else run_len = $urandom_range(7, 12);
      for (int k = 0; k < run_len; k++) send_item(random_value(), k == run_len - 1);
      sent += run_len;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_runs();
    test_extremes();
    test_equal_values();
    test_descending();
    test_full_capacity();
    test_overflow();
    test_random_runs();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sms_pkg.sv
rtl/sms_bank.sv
rtl/stable_merge_sorter.sv
rtl/sms_checker.sv
bench/stable_merge_sorter_tb.sv
